/* design/imu_sample_fifo_with_stamp_check_defines.svh */
// assertion helpers for the imu sample fifo
`ifndef IMU_SAMPLE_FIFO_WITH_STAMP_CHECK_DEFINES_SVH
`define IMU_SAMPLE_FIFO_WITH_STAMP_CHECK_DEFINES_SVH

// condition must hold at every edge out of reset
`define ISFSC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ISFSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/isfsc_pkg.sv */
package isfsc_pkg;

  localparam int DEFAULT_DEPTH = 64;

  // sample word layout, shared by the input word and the sample ram
  localparam int SAMPLE_W  = 296;
  localparam int STAMP_LSB = 40;
  localparam int STAMP_W   = 64;
  localparam int STAT_W    = 64;
  localparam int CTR_W     = 32;
  localparam int FILL_W    = 7;
  localparam int OUT_W     = 368;
  localparam int IN_USER_W = 5;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    SEL_PUSHED   = 3'd0,
    SEL_POPPED   = 3'd1,
    SEL_PEAK     = 3'd2,
    SEL_BACKWARD = 3'd3,
    SEL_GAP      = 3'd4,
    SEL_OLDEST   = 3'd5
  } sel_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

  typedef struct packed {
    logic [CTR_W-1:0] pushed;
    logic [CTR_W-1:0] popped;
    logic [CTR_W-1:0] backward;
    logic [CTR_W-1:0] gap;
  } stats_t;

  typedef struct packed {
    logic               push;
    logic               pop;
    logic [STAMP_W-1:0] stamp;
  } mon_ev_t;

endpackage

/* design/isfsc_ram.sv */
module isfsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/isfsc_monitor.sv */
module isfsc_monitor #(
  parameter int CNT_W = 7
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [isfsc_pkg::STAT_W-1:0]    cfg_data_i,
  input  isfsc_pkg::mon_ev_t              ev_i,
  input  logic [CNT_W-1:0]                level_i,
  output isfsc_pkg::stats_t               stats_o,
  output logic [CNT_W-1:0]                peak_o
);
  import isfsc_pkg::*;

  logic [STAT_W-1:0]  thr_q;
  logic [STAMP_W-1:0] last_q, last_d;
  stats_t             stats_q, stats_d;
  logic [CNT_W-1:0]   peak_q, peak_d;
  logic [STAMP_W-1:0] step;

  function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
    return (v == '1) ? v : v + CTR_W'(1);
  endfunction

  assign step = ev_i.stamp - last_q;

  always_comb begin
    stats_d = stats_q;
    last_d  = last_q;
    peak_d  = peak_q;
    if (ev_i.push) begin
      // a zero previous stamp means nothing to compare against
      if (last_q != '0) begin
        if (ev_i.stamp <= last_q) begin
          stats_d.backward = sat_inc(stats_q.backward);
        end else if (step > thr_q) begin
          stats_d.gap = sat_inc(stats_q.gap);
        end
      end
      last_d        = ev_i.stamp;
      stats_d.pushed = sat_inc(stats_q.pushed);
      if (level_i > peak_q) begin
        peak_d = level_i;
      end
    end
    if (ev_i.pop) begin
      stats_d.popped = sat_inc(stats_q.popped);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= '0;
      last_q  <= '0;
      stats_q <= '0;
      peak_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
      last_q  <= last_d;
      stats_q <= stats_d;
      peak_q  <= peak_d;
    end
  end

  assign stats_o = stats_q;
  assign peak_o  = peak_q;

endmodule

/* design/imu_sample_fifo_with_stamp_check.sv */
// IMU sample queue with a timestamp monitor. Each input word carries one command in tuser
// (push, pop, clear or statistic read) and gives exactly one result word. Samples sit in a
// single DEPTH-entry ram, one full sample per row. Push, clear and statistic reads load
// their result as they are taken, so they can be taken every cycle while the output
// register is free; a pop or an oldest-stamp read waits in ST_READ, because the sample ram
// returns its registered read data in the cycle after the address. The result word sits
// in an output register, and a new command is taken while it waits as long as that
// register is freed in the same cycle. The ram needs no reset: only pushed rows are read.
`include "imu_sample_fifo_with_stamp_check_defines.svh"

module imu_sample_fifo_with_stamp_check #(
  parameter int DEPTH = isfsc_pkg::DEFAULT_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [isfsc_pkg::STAT_W-1:0]       cfg_data_i,     // gap_threshold_ns
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // sensor_kind, device_handle, sample_stamp, rate_x/y/z_bits, accel_x/y/z_bits
  input  logic [isfsc_pkg::SAMPLE_W-1:0]     s_axis_tdata,
  // command, stat_select
  input  logic [isfsc_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // out_kind, out_handle, out_stamp, out_rate_x/y/z, out_accel_x/y/z, fill_level,
  // stat_value, one zero pad bit
  output logic [isfsc_pkg::OUT_W-1:0]        m_axis_tdata,
  // ok
  output logic [0:0]                         m_axis_tuser
);
  import isfsc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  state_e             state_q, state_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               pend_pop_q, pend_pop_d;
  logic               out_valid_q, out_valid_d;
  logic [OUT_W-1:0]   out_data_q, out_data_d;
  logic               out_ok_q, out_ok_d;

  logic               in_acc;
  logic               full;
  logic               ram_we, ram_re;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic               res_load, res_ok;
  logic [SAMPLE_W-1:0] res_sample;
  logic [STAT_W-1:0]  res_stat;
  logic [FILL_W+CNT_W-1:0] fill_ext;
  mon_ev_t            mon_ev;
  stats_t             stats;
  logic [CNT_W-1:0]   peak;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign full          = (cnt_q == CNT_W'(DEPTH));

  always_comb begin
    state_d    = state_q;
    rd_ptr_d   = rd_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    cnt_d      = cnt_q;
    pend_pop_d = pend_pop_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    res_load   = 1'b0;
    res_ok     = 1'b0;
    res_sample = '0;
    res_stat   = '0;
    mon_ev     = '{push: 1'b0, pop: 1'b0, stamp: s_axis_tdata[STAMP_LSB +: STAMP_W]};
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_e'(s_axis_tuser[1:0]))
            CMD_PUSH: begin
              res_load = 1'b1;
              if (!full) begin
                ram_we      = 1'b1;
                wr_ptr_d    = ptr_next(wr_ptr_q);
                cnt_d       = cnt_q + CNT_W'(1);
                mon_ev.push = 1'b1;
                res_ok      = 1'b1;
              end
            end
            CMD_POP: begin
              if (cnt_q != '0) begin
                ram_re     = 1'b1;
                rd_ptr_d   = ptr_next(rd_ptr_q);
                cnt_d      = cnt_q - CNT_W'(1);
                mon_ev.pop = 1'b1;
                pend_pop_d = 1'b1;
                state_d    = ST_READ;
              end else begin
                res_load = 1'b1;
              end
            end
            CMD_CLEAR: begin
              res_load = 1'b1;
              res_ok   = 1'b1;
              res_stat = STAT_W'(cnt_q);
              cnt_d    = '0;
              rd_ptr_d = '0;
              wr_ptr_d = '0;
            end
            CMD_READ: begin
              res_load = 1'b1;
              res_ok   = 1'b1;
              case (sel_e'(s_axis_tuser[4:2]))
                SEL_PUSHED:   res_stat = STAT_W'(stats.pushed);
                SEL_POPPED:   res_stat = STAT_W'(stats.popped);
                SEL_PEAK:     res_stat = STAT_W'(peak);
                SEL_BACKWARD: res_stat = STAT_W'(stats.backward);
                SEL_GAP:      res_stat = STAT_W'(stats.gap);
                SEL_OLDEST: begin
                  if (cnt_q != '0) begin
                    ram_re     = 1'b1;
                    pend_pop_d = 1'b0;
                    state_d    = ST_READ;
                    res_load   = 1'b0;
                  end
                end
                default: res_ok = 1'b0;
              endcase
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        if (!out_valid_q || m_axis_tready) begin
          res_load = 1'b1;
          res_ok   = 1'b1;
          if (pend_pop_q) begin
            res_sample = ram_rdata;
          end else begin
            res_stat = ram_rdata[STAMP_LSB +: STAMP_W];
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // fill level is the count after the item, kept to its low bits
  assign fill_ext = {{FILL_W{1'b0}}, cnt_d};

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_ok_d    = out_ok_q;
    if (res_load) begin
      out_valid_d = 1'b1;
      out_data_d  = {1'b0, res_stat, fill_ext[FILL_W-1:0], res_sample};
      out_ok_d    = res_ok;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      cnt_q       <= '0;
      pend_pop_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      cnt_q       <= cnt_d;
      pend_pop_q  <= pend_pop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_ok_q   <= out_ok_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ok_q;

  isfsc_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (s_axis_tdata),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  isfsc_monitor #(
    .CNT_W (CNT_W)
  ) u_monitor (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .ev_i       (mon_ev),
    .level_i    (cnt_d),
    .stats_o    (stats),
    .peak_o     (peak)
  );

  `ISFSC_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "entry count above depth")
  `ISFSC_ASSERT_ALWAYS(a_empty_ptrs, (cnt_q != '0) || (rd_ptr_q == wr_ptr_q),
                       "empty queue with unequal pointers")
  `ISFSC_ASSERT_ALWAYS(a_pop_le_push, stats.popped <= stats.pushed, "more pops than pushes")
  `ISFSC_ASSERT_NEXT(a_pop_reads, in_acc && (s_axis_tuser[1:0] == CMD_POP) && (cnt_q != '0),
                     (state_q == ST_READ) && pend_pop_q, "pop did not start a ram read")

endmodule

/* tb/sv/imu_fifo_checker.sv */
`timescale 1ns / 100ps

module imu_fifo_checker #(
  parameter int DEPTH = isfsc_pkg::DEFAULT_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [isfsc_pkg::STAT_W-1:0]    cfg_data_i,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [isfsc_pkg::SAMPLE_W-1:0]  s_tdata_i,
  input  logic [isfsc_pkg::IN_USER_W-1:0] s_tuser_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic [isfsc_pkg::OUT_W-1:0]     m_tdata_i,
  input  logic [0:0]                      m_tuser_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import isfsc_pkg::*;

  // kind sits in the lowest bits, same order as the stream word
  typedef struct packed {
    logic [31:0]        accel_z;
    logic [31:0]        accel_y;
    logic [31:0]        accel_x;
    logic [31:0]        rate_z;
    logic [31:0]        rate_y;
    logic [31:0]        rate_x;
    logic [STAMP_W-1:0] stamp;
    logic [31:0]        handle;
    logic [7:0]         kind;
  } sample_t;

  typedef struct packed {
    logic               pad;
    logic [STAT_W-1:0]  stat;
    logic [FILL_W-1:0]  fill;
    sample_t            smp;
  } result_word_t;

  typedef struct packed {
    logic         ok;
    result_word_t word;
  } fifo_result_t;

  fifo_result_t expected_q[$];

  sample_t           sample_ram [DEPTH];
  int unsigned       rd_ptr;
  int unsigned       wr_ptr;
  int unsigned       entry_cnt;
  int unsigned       peak_cnt;
  logic [STAMP_W-1:0] last_stamp;
  logic [STAMP_W-1:0] gap_limit;
  logic [CTR_W-1:0]  pushed_cnt;
  logic [CTR_W-1:0]  popped_cnt;
  logic [CTR_W-1:0]  backward_cnt;
  logic [CTR_W-1:0]  gap_cnt;

  function automatic logic [CTR_W-1:0] bump(logic [CTR_W-1:0] v);
    return (v == '1) ? v : v + CTR_W'(1);
  endfunction

  function automatic int unsigned ptr_next(int unsigned p);
    return (p + 1 >= DEPTH) ? 0 : p + 1;
  endfunction

  task automatic predict_word(input logic [IN_USER_W-1:0] user, input sample_t smp);
    cmd_e         cmd;
    logic [2:0]   sel;
    fifo_result_t res;
    cmd = cmd_e'(user[1:0]);
    sel = user[4:2];
    res = '0;
    case (cmd)
      CMD_PUSH: begin
        if (entry_cnt < DEPTH) begin
          // a zero last stamp disables the check
          if (last_stamp != '0) begin
            if (smp.stamp <= last_stamp) begin
              backward_cnt = bump(backward_cnt);
            end else if (smp.stamp - last_stamp > gap_limit) begin
              gap_cnt = bump(gap_cnt);
            end
          end
          last_stamp = smp.stamp;
          sample_ram[wr_ptr] = smp;
          wr_ptr = ptr_next(wr_ptr);
          entry_cnt++;
          pushed_cnt = bump(pushed_cnt);
          if (entry_cnt > peak_cnt) peak_cnt = entry_cnt;
          res.ok = 1'b1;
        end
      end
      CMD_POP: begin
        if (entry_cnt != 0) begin
          res.word.smp = sample_ram[rd_ptr];
          rd_ptr = ptr_next(rd_ptr);
          entry_cnt--;
          popped_cnt = bump(popped_cnt);
          res.ok = 1'b1;
        end
      end
      CMD_CLEAR: begin
        res.word.stat = STAT_W'(entry_cnt);
        entry_cnt = 0;
        rd_ptr = 0;
        wr_ptr = 0;
        res.ok = 1'b1;
      end
      default: begin
        res.ok = 1'b1;
        case (sel)
          SEL_PUSHED:   res.word.stat = STAT_W'(pushed_cnt);
          SEL_POPPED:   res.word.stat = STAT_W'(popped_cnt);
          SEL_PEAK:     res.word.stat = STAT_W'(peak_cnt);
          SEL_BACKWARD: res.word.stat = STAT_W'(backward_cnt);
          SEL_GAP:      res.word.stat = STAT_W'(gap_cnt);
          SEL_OLDEST:   res.word.stat = (entry_cnt != 0) ? sample_ram[rd_ptr].stamp : '0;
          default:      res.ok = 1'b0;
        endcase
      end
    endcase
    res.word.fill = FILL_W'(entry_cnt);
    expected_q.insert(expected_q.size(), res);
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  task automatic check_word(input logic ok, input result_word_t got);
    fifo_result_t want;
    if (expected_q.size() == 0) begin
      fail_count_o++;
      $display("%0t: unexpected result word, expected none, actual ok=%b %h",
               $time, ok, got);
    end else begin
      want = expected_q[0];
      expected_q.delete(0);
      check_field("ok", 64'(want.ok), 64'(ok));
      check_field("out_kind", 64'(want.word.smp.kind), 64'(got.smp.kind));
      check_field("out_handle", 64'(want.word.smp.handle), 64'(got.smp.handle));
      check_field("out_stamp", want.word.smp.stamp, got.smp.stamp);
      check_field("out_rate_x", 64'(want.word.smp.rate_x), 64'(got.smp.rate_x));
      check_field("out_rate_y", 64'(want.word.smp.rate_y), 64'(got.smp.rate_y));
      check_field("out_rate_z", 64'(want.word.smp.rate_z), 64'(got.smp.rate_z));
      check_field("out_accel_x", 64'(want.word.smp.accel_x), 64'(got.smp.accel_x));
      check_field("out_accel_y", 64'(want.word.smp.accel_y), 64'(got.smp.accel_y));
      check_field("out_accel_z", 64'(want.word.smp.accel_z), 64'(got.smp.accel_z));
      check_field("fill_level", 64'(want.word.fill), 64'(got.fill));
      check_field("stat_value", want.word.stat, got.stat);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q.delete();
      rd_ptr       = 0;
      wr_ptr       = 0;
      entry_cnt    = 0;
      peak_cnt     = 0;
      last_stamp   = '0;
      gap_limit    = '0;
      pushed_cnt   = '0;
      popped_cnt   = '0;
      backward_cnt = '0;
      gap_cnt      = '0;
      pending_o    = 0;
    end else begin
      // result first: it can never belong to a word taken at this same edge
      if (m_tvalid_i && m_tready_i) check_word(m_tuser_i[0], result_word_t'(m_tdata_i));
      if (cfg_valid_i && cfg_ready_i) gap_limit = cfg_data_i;
      if (s_tvalid_i && s_tready_i) predict_word(s_tuser_i, sample_t'(s_tdata_i));
      pending_o = expected_q.size();
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import isfsc_pkg::*;

  localparam int LIMIT  = 400000;
  localparam int SETTLE = 8;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [STAT_W-1:0]    cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [SAMPLE_W-1:0]  s_axis_tdata;
  logic [IN_USER_W-1:0] s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic [0:0]           m_axis_tuser;

  int fail_count;
  int pending;

  logic [STAMP_W-1:0] last_sent_stamp;
  logic [STAT_W-1:0]  cur_gap;
  bit                 filling;
  int                 tilt_left;
  int                 stall_mode;
  int                 mode_left;
  int                 stall_left;

  imu_sample_fifo_with_stamp_check i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  imu_fifo_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (LIMIT) @(posedge clk_i);
    $display("imu_sample_fifo_with_stamp_check test failed");
    $finish;
  end

  // receiver: free, coin flip, one in four, or occasional long stalls
  initial begin
    m_axis_tready = 1'b0;
    mode_left     = 0;
    stall_left    = 0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(16, 200);
      end
      mode_left--;
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= (mode_left % 4 == 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
          end else begin
            m_axis_tready <= 1'b1;
            stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 9) : 0;
          end
        end
      endcase
    end
  end

  task automatic send_word(input cmd_e cmd, input logic [2:0] sel,
                           input logic [SAMPLE_W-1:0] data);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {sel, cmd};
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic pause(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  function automatic logic [SAMPLE_W-1:0] pattern_sample(input logic [STAMP_W-1:0] stamp,
                                                         input logic [7:0] kind,
                                                         input logic [31:0] fill);
    return {{6{fill}}, stamp, fill, kind};
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample(input logic [STAMP_W-1:0] stamp);
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            stamp, $urandom, 8'($urandom)};
  endfunction

  // mostly steps around the threshold, some backward, zero or wild stamps
  function automatic logic [STAMP_W-1:0] next_stamp();
    int                 r;
    logic [STAMP_W-1:0] delta;
    logic [STAMP_W-1:0] st;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      case ($urandom_range(0, 3))
        0:       delta = cur_gap;
        1:       delta = cur_gap + STAMP_W'(1);
        2:       delta = cur_gap - STAMP_W'(1);
        default: delta = STAMP_W'($urandom_range(1, 1000));
      endcase
      st = last_sent_stamp + delta;
    end else if (r < 82) begin
      st = last_sent_stamp - STAMP_W'($urandom_range(0, 40));
    end else if (r < 86) begin
      st = '0;
    end else begin
      st = {$urandom, $urandom};
    end
    last_sent_stamp = st;
    return st;
  endfunction

  task automatic write_gap(input logic [STAT_W-1:0] value);
    wait (pending == 0);
    repeat (SETTLE) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_gap = value;
  endtask

  task automatic random_word();
    int pick;
    if (tilt_left == 0) begin
      filling   = !filling;
      tilt_left = $urandom_range(20, 140);
    end
    tilt_left--;
    pick = $urandom_range(0, 199);
    if (pick == 0) begin
      send_word(CMD_CLEAR, 3'($urandom), random_sample({$urandom, $urandom}));
    end else if (pick < 16) begin
      send_word(CMD_READ, 3'($urandom_range(0, 7)), random_sample({$urandom, $urandom}));
    end else if (pick < (filling ? 160 : 50)) begin
      send_word(CMD_PUSH, 3'($urandom), random_sample(next_stamp()));
    end else begin
      send_word(CMD_POP, 3'($urandom), random_sample({$urandom, $urandom}));
    end
  endtask

  task automatic run_phase(input int n_words);
    int burst;
    burst = 0;
    for (int i = 0; i < n_words; i++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
        burst = $urandom_range(1, 16);
      end
      burst--;
      random_word();
    end
    pause(1);
  endtask

  initial begin
    logic [STAT_W-1:0] gap_plan [5];
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = '0;
    cur_gap         = '0;
    last_sent_stamp = '0;
    filling         = 1'b0;
    tilt_left       = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset threshold of zero: any forward step is a gap
    send_word(CMD_READ, SEL_OLDEST, '0);
    send_word(CMD_POP, '0, '0);
    send_word(CMD_PUSH, '0, pattern_sample('0, 8'hff, '1));
    send_word(CMD_PUSH, '0, pattern_sample(64'd5, 8'h00, '0));
    send_word(CMD_PUSH, '0, pattern_sample(64'd5, 8'h5a, 32'ha5a5_5a5a));
    send_word(CMD_PUSH, '0, pattern_sample(64'd3, 8'ha5, 32'h5a5a_a5a5));
    send_word(CMD_PUSH, '0, pattern_sample(64'd4, 8'h01, 32'h8000_0001));
    send_word(CMD_PUSH, '0, pattern_sample('1, 8'h80, 32'h7fff_fffe));
    for (int s = 0; s < 8; s++) send_word(CMD_READ, 3'(s), '0);
    send_word(CMD_POP, '0, '0);
    send_word(CMD_POP, '0, '0);
    send_word(CMD_READ, SEL_OLDEST, '0);
    send_word(CMD_CLEAR, '0, '0);
    send_word(CMD_POP, '0, '0);
    pause(1);

    // step of exactly the threshold passes, one more is a gap
    write_gap(64'd100);
    send_word(CMD_PUSH, '0, random_sample(64'd1000));
    send_word(CMD_PUSH, '0, random_sample(64'd1100));
    send_word(CMD_PUSH, '0, random_sample(64'd1201));
    send_word(CMD_READ, SEL_GAP, '0);
    send_word(CMD_CLEAR, '0, '0);
    pause(1);
    last_sent_stamp = 64'd1201;

    gap_plan[0] = '1;
    gap_plan[1] = '0;
    gap_plan[2] = STAT_W'($urandom_range(1, 5000));
    gap_plan[3] = {$urandom, $urandom};
    gap_plan[4] = 64'd1;
    foreach (gap_plan[p]) begin
      write_gap(gap_plan[p]);
      run_phase(310);
    end

    wait (pending == 0);
    repeat (2 * SETTLE) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("imu_sample_fifo_with_stamp_check test passed");
    end else begin
      $display("imu_sample_fifo_with_stamp_check test failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/isfsc_pkg.sv
design/isfsc_ram.sv
design/isfsc_monitor.sv
design/imu_sample_fifo_with_stamp_check.sv
tb/sv/imu_fifo_checker.sv
tb/sv/testbench.sv
